[src/elm_pkg.sv]
// Shared constants, types and codes for the element-wise list merger.
package elm_pkg;

    localparam int MAX_LEN    = 64;
    localparam int ADDR_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W      = $clog2(MAX_LEN + 1);
    localparam int VAL_W      = 32;
    localparam int FRAC_W     = 16;
    localparam int IP_W       = VAL_W - FRAC_W;
    localparam int SUM_W      = 37;
    localparam int ISUM_W     = 22;
    localparam int CNT_W      = 5;
    localparam int COUNT_FULL = 31;
    localparam int CMDQ_DEPTH = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_MERGE_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MERGE_MODE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_CAP        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGER_AVERAGE = 2'd3;

    localparam logic [2:0] MODE_APPEND  = 3'd0;
    localparam logic [2:0] MODE_HIGHEST = 3'd1;
    localparam logic [2:0] MODE_AVERAGE = 3'd4;

    typedef enum logic [1:0] {
        KIND_APPEND,
        KIND_HIGHEST,
        KIND_AVERAGE
    } merge_kind_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_FETCH,
        B_EVAL,
        B_DIVIDE,
        B_ROUND,
        B_SEND
    } back_state_t;

    // One per-index store entry; valid is false until the entry is written in this set
    typedef struct packed {
        logic                     valid;
        logic signed [VAL_W-1:0]  peak;
        logic signed [SUM_W-1:0]  sum;
        logic signed [ISUM_W-1:0] isum;
        logic [CNT_W-1:0]         cnt;
    } entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        entry_t            entry;
    } entry_wr_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [VAL_W-1:0]  data;
    } cat_wr_t;

    // Drain command handed from front to back at end of set
    typedef struct packed {
        merge_kind_t      kind;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] cat_len;
        logic             ovf;
        logic             int_avg;
    } cmd_t;

endpackage

[src/elm_if.sv]
// Channel interfaces: input items, result items and configuration writes.
interface elm_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [elm_pkg::VAL_W-1:0] element_value;
    logic                             end_of_list;
    logic                             empty_marker;
    logic                             end_of_set;

    modport source (output valid, element_value, end_of_list, empty_marker, end_of_set,
                    input ready);
    modport sink   (input valid, element_value, end_of_list, empty_marker, end_of_set,
                    output ready);
endinterface

interface elm_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [elm_pkg::VAL_W-1:0] result_value;
    logic                             is_last;
    logic                             empty_result;
    logic                             overflow;

    modport source (output valid, result_value, is_last, empty_result, overflow,
                    input ready);
    modport sink   (input valid, result_value, is_last, empty_result, overflow,
                    output ready);
endinterface

interface elm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [elm_pkg::CFG_IDX_W-1:0]       index;
    logic [elm_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[src/elementwise_list_merger.sv]
// Top level of the element-wise list merger.
//
// Channels: items (element_value in Q16.16 with end_of_list, empty_marker and
// end_of_set marks), results (result_value, is_last, empty_result, overflow)
// and cfg (index/data register writes, always ready; they are to be written
// only while idle, which the block does not enforce). Within a set an item
// is taken every cycle: the front end accumulates each element into the
// per-index stores with a read-modify-write in the stage after intake and
// a bypass for back-to-back hits on the same index. The transfer that
// carries end_of_set closes the set. items.ready then stays low until the
// last result of that set has been transferred. The command queue hands the
// set to the drain engine, which goes straight to send when the merged length
// is zero and otherwise reads, selects and sends each result; average entries
// that some list reached also pass the 37-step divider and a rounding state.
// Such a zero-length set produces one result with empty_result set.
// When the receiver stalls, the result register holds and the drain waits.
// Reset clears all control state and the per-index valid bits; the stores
// need no clearing pass since each entry is marked valid when written.
module elementwise_list_merger (
    input  logic      clk,
    input  logic      rst_n,
    elm_in_if.sink    items,
    elm_out_if.source results,
    elm_cfg_if.sink   cfg
);

    elm_pkg::cmd_t              push_cmd;
    elm_pkg::cmd_t              pop_cmd;
    logic                       cmd_push;
    logic                       cmd_pop;
    logic                       cmd_full;
    logic                       cmd_empty;
    logic                       drain_done;
    logic                       back_owns;
    logic [elm_pkg::ADDR_W-1:0] front_rd_addr;
    logic [elm_pkg::ADDR_W-1:0] back_rd_addr;
    logic [elm_pkg::ADDR_W-1:0] rd_addr;
    elm_pkg::entry_t            rd_entry;
    logic [elm_pkg::VAL_W-1:0]  rd_cat;
    elm_pkg::entry_wr_t         entry_wr;
    elm_pkg::cat_wr_t           cat_wr;

    assign rd_addr = back_owns ? back_rd_addr : front_rd_addr;

    elm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .cfg        (cfg),
        .drain_done (drain_done),
        .cmd_full   (cmd_full),
        .cmd_push   (cmd_push),
        .cmd        (push_cmd),
        .rd_addr    (front_rd_addr),
        .rd_entry   (rd_entry),
        .entry_wr   (entry_wr),
        .cat_wr     (cat_wr)
    );

    elm_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (push_cmd),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (pop_cmd),
        .empty (cmd_empty)
    );

    elm_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .entry_wr (entry_wr),
        .cat_wr   (cat_wr),
        .clear    (drain_done),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .rd_cat   (rd_cat)
    );

    elm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .results    (results),
        .cmd_empty  (cmd_empty),
        .cmd        (pop_cmd),
        .cmd_pop    (cmd_pop),
        .owns_store (back_owns),
        .rd_addr    (back_rd_addr),
        .rd_entry   (rd_entry),
        .rd_cat     (rd_cat),
        .drain_done (drain_done)
    );

endmodule

[src/elm_store.sv]
// Per-index stores, concatenation store and per-index valid bits.
module elm_store (
    input  logic                           clk,
    input  logic                           rst_n,
    input  elm_pkg::entry_wr_t             entry_wr,
    input  elm_pkg::cat_wr_t               cat_wr,
    input  logic                           clear,
    input  logic [elm_pkg::ADDR_W-1:0]     rd_addr,
    output elm_pkg::entry_t                rd_entry,
    output logic [elm_pkg::VAL_W-1:0]      rd_cat
);

    logic [elm_pkg::VAL_W-1:0]  peak_mem   [elm_pkg::MAX_LEN];
    logic [elm_pkg::SUM_W-1:0]  sum_mem    [elm_pkg::MAX_LEN];
    logic [elm_pkg::ISUM_W-1:0] isum_mem   [elm_pkg::MAX_LEN];
    logic [elm_pkg::CNT_W-1:0]  cnt_mem    [elm_pkg::MAX_LEN];
    logic [elm_pkg::VAL_W-1:0]  cat_mem    [elm_pkg::MAX_LEN];
    logic [elm_pkg::MAX_LEN-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (entry_wr.we)
        begin
            peak_mem[entry_wr.addr] <= entry_wr.entry.peak;
            sum_mem[entry_wr.addr]  <= entry_wr.entry.sum;
            isum_mem[entry_wr.addr] <= entry_wr.entry.isum;
            cnt_mem[entry_wr.addr]  <= entry_wr.entry.cnt;
        end
        if (cat_wr.we)
        begin
            cat_mem[cat_wr.addr] <= cat_wr.data;
        end
        rd_entry.valid <= valid_reg[rd_addr];
        rd_entry.peak  <= peak_mem[rd_addr];
        rd_entry.sum   <= sum_mem[rd_addr];
        rd_entry.isum  <= isum_mem[rd_addr];
        rd_entry.cnt   <= cnt_mem[rd_addr];
        rd_cat         <= cat_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (entry_wr.we)
            begin
                valid_reg[entry_wr.addr] <= 1'b1;
            end
        end
    end

endmodule

[src/elm_front.sv]
// Front end: configuration registers, item intake and per-index accumulate.
module elm_front (
    input  logic                       clk,
    input  logic                       rst_n,
    elm_in_if.sink                     items,
    elm_cfg_if.sink                    cfg,
    input  logic                       drain_done,
    input  logic                       cmd_full,
    output logic                       cmd_push,
    output elm_pkg::cmd_t              cmd,
    output logic [elm_pkg::ADDR_W-1:0] rd_addr,
    input  elm_pkg::entry_t            rd_entry,
    output elm_pkg::entry_wr_t         entry_wr,
    output elm_pkg::cat_wr_t           cat_wr
);

    localparam int LW = elm_pkg::LEN_W;

    logic                              merge_enable_reg;
    logic [2:0]                        merge_mode_reg;
    logic signed [7:0]                 size_cap_reg;
    logic                              int_avg_reg;

    logic                              busy_reg, busy_next;
    logic [LW-1:0]                     position_reg, position_next;
    logic [LW-1:0]                     longest_reg, longest_next;
    logic [LW-1:0]                     wr_index_reg, wr_index_next;
    logic                              dropped_reg, dropped_next;
    logic                              cat_dropped_reg, cat_dropped_next;

    logic                              s1_valid_reg;
    logic                              s1_upd_reg;
    logic                              s1_eos_reg;
    logic [elm_pkg::ADDR_W-1:0]        s1_addr_reg;
    logic signed [elm_pkg::VAL_W-1:0]  s1_value_reg;
    elm_pkg::cmd_t                     s1_cmd_reg, s1_cmd_next;

    logic                              fwd_reg, fwd_next;
    elm_pkg::entry_t                   fwd_entry_reg;

    logic                              accept;
    logic                              has_elem;
    logic                              in_range;
    logic                              cat_ok;
    logic [LW-1:0]                     pos_after;
    logic [LW-1:0]                     longest_after;
    logic [LW-1:0]                     wr_after;
    logic                              drop_after;
    logic                              cat_drop_after;
    logic [2:0]                        mode_eff;
    logic [6:0]                        cap_mag;
    logic                              cap_over;

    elm_pkg::entry_t                   old;
    elm_pkg::entry_t                   upd;
    logic [elm_pkg::CNT_W-1:0]         old_cnt;
    logic                              first;
    logic signed [elm_pkg::IP_W-1:0]   ip_raw;
    logic signed [elm_pkg::IP_W-1:0]   ip;

    assign cfg.ready   = 1'b1;
    assign items.ready = !busy_reg && !cmd_full;
    assign accept      = items.valid && items.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            merge_enable_reg <= 1'b0;
            merge_mode_reg   <= elm_pkg::MODE_APPEND;
            size_cap_reg     <= -8'sd1;
            int_avg_reg      <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                elm_pkg::CFG_MERGE_ENABLE:    merge_enable_reg <= cfg.data[0];
                elm_pkg::CFG_MERGE_MODE:      merge_mode_reg   <= cfg.data[2:0];
                elm_pkg::CFG_SIZE_CAP:        size_cap_reg     <= cfg.data;
                elm_pkg::CFG_INTEGER_AVERAGE: int_avg_reg      <= cfg.data[0];
                default:                      ;
            endcase
        end
    end

    // Intake bookkeeping and drain command
    always_comb
    begin
        has_elem       = !items.empty_marker;
        in_range       = position_reg < LW'(elm_pkg::MAX_LEN);
        cat_ok         = wr_index_reg < LW'(elm_pkg::MAX_LEN);
        pos_after      = (has_elem && in_range) ? position_reg + 1'b1 : position_reg;
        longest_after  = (pos_after > longest_reg) ? pos_after : longest_reg;
        wr_after       = (has_elem && cat_ok) ? wr_index_reg + 1'b1 : wr_index_reg;
        drop_after     = dropped_reg || (has_elem && !in_range);
        cat_drop_after = cat_dropped_reg || (has_elem && !cat_ok);

        mode_eff = merge_enable_reg ? merge_mode_reg : elm_pkg::MODE_APPEND;
        cap_mag  = size_cap_reg[6:0];
        cap_over = {1'b0, cap_mag} > 8'(elm_pkg::MAX_LEN);

        s1_cmd_next.int_avg = int_avg_reg;
        s1_cmd_next.cat_len = wr_after;
        if (mode_eff == elm_pkg::MODE_HIGHEST || mode_eff == elm_pkg::MODE_AVERAGE)
        begin
            s1_cmd_next.kind = (mode_eff == elm_pkg::MODE_HIGHEST) ?
                               elm_pkg::KIND_HIGHEST : elm_pkg::KIND_AVERAGE;
            s1_cmd_next.len  = longest_after;
            s1_cmd_next.ovf  = drop_after;
        end
        else if (!size_cap_reg[7])
        begin
            s1_cmd_next.kind = elm_pkg::KIND_APPEND;
            s1_cmd_next.len  = cap_over ? LW'(elm_pkg::MAX_LEN) : LW'(cap_mag);
            s1_cmd_next.ovf  = cat_drop_after && cap_over;
        end
        else
        begin
            s1_cmd_next.kind = elm_pkg::KIND_APPEND;
            s1_cmd_next.len  = wr_after;
            s1_cmd_next.ovf  = cat_drop_after;
        end

        position_next    = position_reg;
        longest_next     = longest_reg;
        wr_index_next    = wr_index_reg;
        dropped_next     = dropped_reg;
        cat_dropped_next = cat_dropped_reg;
        busy_next        = busy_reg;
        if (drain_done)
        begin
            busy_next = 1'b0;
        end
        if (accept)
        begin
            if (items.end_of_set)
            begin
                position_next    = '0;
                longest_next     = '0;
                wr_index_next    = '0;
                dropped_next     = 1'b0;
                cat_dropped_next = 1'b0;
                busy_next        = 1'b1;
            end
            else
            begin
                position_next    = (items.empty_marker || items.end_of_list) ? '0 : pos_after;
                longest_next     = longest_after;
                wr_index_next    = wr_after;
                dropped_next     = drop_after;
                cat_dropped_next = cat_drop_after;
            end
        end

        rd_addr      = position_reg[elm_pkg::ADDR_W-1:0];
        cat_wr.we    = accept && has_elem && cat_ok;
        cat_wr.addr  = wr_index_reg[elm_pkg::ADDR_W-1:0];
        cat_wr.data  = items.element_value;
    end

    // Read-modify-write of the per-index entry, in the cycle after intake
    always_comb
    begin
        old     = fwd_reg ? fwd_entry_reg : rd_entry;
        old_cnt = old.valid ? old.cnt : '0;
        first   = (old_cnt == '0);
        ip_raw  = s1_value_reg[elm_pkg::VAL_W-1:elm_pkg::FRAC_W];
        // truncate toward zero: floor plus one for negatives with a fraction
        ip      = ip_raw + elm_pkg::IP_W'(s1_value_reg[elm_pkg::VAL_W-1] &&
                                          (s1_value_reg[elm_pkg::FRAC_W-1:0] != '0));

        upd       = old;
        upd.valid = 1'b1;
        if (first || s1_value_reg > old.peak)
        begin
            upd.peak = s1_value_reg;
        end
        if (first)
        begin
            upd.sum  = '0;
            upd.isum = '0;
        end
        if (old_cnt < elm_pkg::CNT_W'(elm_pkg::COUNT_FULL))
        begin
            upd.sum  = upd.sum + elm_pkg::SUM_W'(s1_value_reg);
            upd.isum = upd.isum + elm_pkg::ISUM_W'(ip);
            upd.cnt  = old_cnt + 1'b1;
        end

        entry_wr.we    = s1_valid_reg && s1_upd_reg;
        entry_wr.addr  = s1_addr_reg;
        entry_wr.entry = upd;

        fwd_next = entry_wr.we && accept && has_elem && in_range &&
                   (position_reg[elm_pkg::ADDR_W-1:0] == s1_addr_reg);

        cmd_push = s1_valid_reg && s1_eos_reg;
        cmd      = s1_cmd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            position_reg    <= '0;
            longest_reg     <= '0;
            wr_index_reg    <= '0;
            dropped_reg     <= 1'b0;
            cat_dropped_reg <= 1'b0;
            s1_valid_reg    <= 1'b0;
            fwd_reg         <= 1'b0;
        end
        else
        begin
            busy_reg        <= busy_next;
            position_reg    <= position_next;
            longest_reg     <= longest_next;
            wr_index_reg    <= wr_index_next;
            dropped_reg     <= dropped_next;
            cat_dropped_reg <= cat_dropped_next;
            s1_valid_reg    <= accept;
            fwd_reg         <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_upd_reg   <= has_elem && in_range;
            s1_eos_reg   <= items.end_of_set;
            s1_addr_reg  <= position_reg[elm_pkg::ADDR_W-1:0];
            s1_value_reg <= items.element_value;
            s1_cmd_reg   <= s1_cmd_next;
        end
        fwd_entry_reg <= upd;
    end

endmodule

[src/elm_fifo.sv]
// Short command queue between the front end and the drain engine.
module elm_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  elm_pkg::cmd_t din,
    output logic          full,
    input  logic          pop,
    output elm_pkg::cmd_t dout,
    output logic          empty
);

    localparam int PTR_W = (elm_pkg::CMDQ_DEPTH > 1) ? $clog2(elm_pkg::CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(elm_pkg::CMDQ_DEPTH + 1);

    elm_pkg::cmd_t     entries_reg [elm_pkg::CMDQ_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(elm_pkg::CMDQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(elm_pkg::CMDQ_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(elm_pkg::CMDQ_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

endmodule

[src/elm_div.sv]
// Restoring divider, one quotient bit per cycle, small unsigned divisor.
module elm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [elm_pkg::SUM_W-1:0]  dividend,
    input  logic [elm_pkg::CNT_W-1:0]  divisor,
    output logic                       done,
    output logic [elm_pkg::SUM_W-1:0]  quotient,
    output logic [elm_pkg::CNT_W-1:0]  remainder
);

    localparam int STEP_W = $clog2(elm_pkg::SUM_W + 1);

    logic [elm_pkg::SUM_W-1:0] quot_reg;
    logic [elm_pkg::CNT_W-1:0] rem_reg;
    logic [elm_pkg::CNT_W-1:0] div_reg;
    logic [STEP_W-1:0]         steps_reg;
    logic                      done_reg;
    logic [elm_pkg::CNT_W:0]   shifted;
    logic                      ge;
    logic [elm_pkg::CNT_W:0]   diff;

    always_comb
    begin
        shifted = {rem_reg, quot_reg[elm_pkg::SUM_W-1]};
        ge      = shifted >= {1'b0, div_reg};
        diff    = shifted - {1'b0, div_reg};
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (steps_reg != '0)
        begin
            quot_reg <= {quot_reg[elm_pkg::SUM_W-2:0], ge};
            rem_reg  <= ge ? diff[elm_pkg::CNT_W-1:0] : shifted[elm_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= !start && (steps_reg == STEP_W'(1));
            if (start)
            begin
                steps_reg <= STEP_W'(elm_pkg::SUM_W);
            end
            else if (steps_reg != '0)
            begin
                steps_reg <= steps_reg - 1'b1;
            end
        end
    end

endmodule

[src/elm_back.sv]
// Drain engine: walks the stores after end of set and produces merged results.
module elm_back (
    input  logic                       clk,
    input  logic                       rst_n,
    elm_out_if.source                  results,
    input  logic                       cmd_empty,
    input  elm_pkg::cmd_t              cmd,
    output logic                       cmd_pop,
    output logic                       owns_store,
    output logic [elm_pkg::ADDR_W-1:0] rd_addr,
    input  elm_pkg::entry_t            rd_entry,
    input  logic [elm_pkg::VAL_W-1:0]  rd_cat,
    output logic                       drain_done
);

    localparam int LW = elm_pkg::LEN_W;
    localparam int SW = elm_pkg::SUM_W;
    localparam int VW = elm_pkg::VAL_W;

    elm_pkg::back_state_t      state_reg, state_next;
    elm_pkg::cmd_t             cmd_reg;
    logic [LW-1:0]             idx_reg;
    logic [VW-1:0]             value_reg;
    logic                      last_reg;
    logic                      empty_reg;
    logic                      ovf_reg;
    logic                      neg_reg;
    logic [elm_pkg::CNT_W-1:0] cnt_reg;

    logic                      div_start;
    logic                      div_done;
    logic [SW-1:0]             div_quot;
    logic [elm_pkg::CNT_W-1:0] div_rem;
    logic signed [SW-1:0]      src_val;
    logic [SW-1:0]             src_mag;
    logic                      is_last_idx;
    logic [VW-1:0]             eval_value;
    logic                      round_up;
    logic [SW-1:0]             q_rounded;
    logic [SW-1:0]             q_signed;
    logic [VW-1:0]             round_value;

    elm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (src_mag),
        .divisor   (rd_entry.cnt),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Datapath helpers
    always_comb
    begin
        src_val     = cmd_reg.int_avg ? SW'(rd_entry.isum) : rd_entry.sum;
        src_mag     = src_val[SW-1] ? SW'(-src_val) : SW'(src_val);
        is_last_idx = (idx_reg + 1'b1 == cmd_reg.len);

        case (cmd_reg.kind)
            elm_pkg::KIND_HIGHEST: eval_value = rd_entry.valid ? rd_entry.peak : '0;
            elm_pkg::KIND_APPEND:  eval_value = (idx_reg < cmd_reg.cat_len) ? rd_cat : '0;
            default:               eval_value = '0;
        endcase

        // fractional mean rounds half away from zero; integer mean truncates
        round_up    = {div_rem, 1'b0} >= {1'b0, cnt_reg};
        q_rounded   = cmd_reg.int_avg ? div_quot : div_quot + SW'(round_up);
        q_signed    = neg_reg ? (~q_rounded + 1'b1) : q_rounded;
        round_value = cmd_reg.int_avg ?
                      {q_signed[VW-elm_pkg::FRAC_W-1:0], {elm_pkg::FRAC_W{1'b0}}} :
                      q_signed[VW-1:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            elm_pkg::B_IDLE:
                if (!cmd_empty)
                begin
                    state_next = (cmd.len == '0) ? elm_pkg::B_SEND : elm_pkg::B_FETCH;
                end
            elm_pkg::B_FETCH:
                state_next = elm_pkg::B_EVAL;
            elm_pkg::B_EVAL:
                if (cmd_reg.kind == elm_pkg::KIND_AVERAGE && rd_entry.valid)
                begin
                    state_next = elm_pkg::B_DIVIDE;
                end
                else
                begin
                    state_next = elm_pkg::B_SEND;
                end
            elm_pkg::B_DIVIDE:
                if (div_done)
                begin
                    state_next = elm_pkg::B_ROUND;
                end
            elm_pkg::B_ROUND:
                state_next = elm_pkg::B_SEND;
            elm_pkg::B_SEND:
                if (results.ready)
                begin
                    state_next = last_reg ? elm_pkg::B_IDLE : elm_pkg::B_FETCH;
                end
            default:
                state_next = elm_pkg::B_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd_pop    = (state_reg == elm_pkg::B_IDLE) && !cmd_empty;
        owns_store = (state_reg != elm_pkg::B_IDLE);
        rd_addr    = idx_reg[elm_pkg::ADDR_W-1:0];
        div_start  = (state_reg == elm_pkg::B_EVAL) &&
                     (cmd_reg.kind == elm_pkg::KIND_AVERAGE) && rd_entry.valid;
        drain_done = (state_reg == elm_pkg::B_SEND) && results.ready && last_reg;

        results.valid        = (state_reg == elm_pkg::B_SEND);
        results.result_value = value_reg;
        results.is_last      = last_reg;
        results.empty_result = empty_reg;
        results.overflow     = ovf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= elm_pkg::B_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_pop)
            begin
                idx_reg <= '0;
            end
            else if (state_reg == elm_pkg::B_SEND && results.ready)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            elm_pkg::B_IDLE:
                if (!cmd_empty)
                begin
                    cmd_reg   <= cmd;
                    value_reg <= '0;
                    last_reg  <= 1'b1;
                    empty_reg <= (cmd.len == '0);
                    ovf_reg   <= cmd.ovf;
                end
            elm_pkg::B_EVAL:
            begin
                value_reg <= eval_value;
                last_reg  <= is_last_idx;
                empty_reg <= 1'b0;
                neg_reg   <= src_val[SW-1];
                cnt_reg   <= rd_entry.cnt;
            end
            elm_pkg::B_ROUND:
                value_reg <= round_value;
            default:
                ;
        endcase
    end

endmodule

[src/elm_checker.sv]
// Port-level assertions for the list merger, bound to the top level.
module elm_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      in_eos,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [elm_pkg::VAL_W-1:0] out_value,
    input logic                      out_last,
    input logic                      out_empty,
    input logic                      out_ovf
);

    // stalled result must hold
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(out_value) && $stable(out_last) &&
            $stable(out_empty) && $stable(out_ovf);
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result changed while stalled");

    // closing a set stops intake until the drain finishes
    property p_eos_blocks;
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_eos |=> !in_ready;
    endproperty
    a_eos_blocks: assert property (p_eos_blocks)
        else $error("items accepted right after end of set");

    property p_no_intake_during_drain;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready;
    endproperty
    a_no_intake_during_drain: assert property (p_no_intake_during_drain)
        else $error("items ready while results pending");

    property p_empty_form;
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_empty |-> out_last && (out_value == '0);
    endproperty
    a_empty_form: assert property (p_empty_form)
        else $error("empty result not a single zero item");

endmodule

bind elementwise_list_merger elm_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .in_eos    (items.end_of_set),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_value (results.result_value),
    .out_last  (results.is_last),
    .out_empty (results.empty_result),
    .out_ovf   (results.overflow)
);

[sim/elementwise_list_merger_tb.sv]
// Testbench for the element-wise list merger: directed and random sets checked against a predictor.
`timescale 1ns / 1ps

module elementwise_list_merger_tb;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
    // modes 2 and 3 fall back to append
    localparam logic [2:0] MODE_ALT2 = 3'd2;
    localparam logic [2:0] MODE_ALT3 = 3'd3;
    localparam int RANDOM_ITEMS = 120;
    localparam int IDLE_SETTLE  = 8;
    localparam int END_SETTLE   = 100;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [31:0] value;
        logic        is_last;
        logic        empty_result;
        logic        overflow;
    } merged_t;

    logic clk;
    logic rst_n;

    elm_in_if  in_if();
    elm_out_if out_if();
    elm_cfg_if cfg_if();

    elementwise_list_merger dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (in_if),
        .results (out_if),
        .cfg     (cfg_if)
    );

    // predictor state
    logic               m_enable;
    logic [2:0]         m_mode;
    logic signed [7:0]  m_cap;
    logic               m_int_avg;
    logic signed [31:0] peak_at [elm_pkg::MAX_LEN];
    longint             sum_at  [elm_pkg::MAX_LEN];
    longint             isum_at [elm_pkg::MAX_LEN];
    int                 cnt_at  [elm_pkg::MAX_LEN];
    logic signed [31:0] cat_at  [elm_pkg::MAX_LEN];
    int                 pos;
    int                 longest;
    int                 wr_pos;
    bit                 idx_dropped;
    bit                 cat_dropped;

    merged_t merged_q[$];
    merged_t head_r;
    int      mismatches;
    int      results_seen;
    int      items_sent;
    bit      src_gaps;
    bit      sink_gaps;
    int      sink_hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(64'd100_000_000);
        $display("elementwise_list_merger: mismatch");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] rand_value();
        int k;
        k = int'($urandom_range(0, 16)) - 8;
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return $urandom_range(0, 393216) - 196608;
            3: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            4: return k * Q_ONE;
            default: return k * Q_ONE + 32'sh0000_8000;  // exact halves
        endcase
    endfunction

    function automatic longint rounded_mean(longint s, longint c);
        longint mag;
        longint q;
        mag = (s < 0) ? -s : s;
        q = mag / c;
        if (2 * (mag % c) >= c)
            q++;
        return (s < 0) ? -q : q;
    endfunction

    function automatic void clear_set_state();
        for (int i = 0; i < elm_pkg::MAX_LEN; i++)
            cnt_at[i] = 0;
        pos = 0;
        longest = 0;
        wr_pos = 0;
        idx_dropped = 1'b0;
        cat_dropped = 1'b0;
    endfunction

    // Folds one accepted item into the per-index and concatenation stores;
    // on end of set queues the merged list.
    task automatic fold_item(input logic signed [31:0] v, input logic eol,
                             input logic mt, input logic eos);
        elm_pkg::merge_kind_t kind;
        int          len;
        int          cap_i;
        bit          ovf;
        longint      r;
        merged_t     m;
        if (!mt)
        begin
            if (pos < elm_pkg::MAX_LEN)
            begin
                if (cnt_at[pos] == 0 || v > peak_at[pos])
                    peak_at[pos] = v;
                if (cnt_at[pos] == 0)
                begin
                    sum_at[pos] = 0;
                    isum_at[pos] = 0;
                end
                if (cnt_at[pos] < elm_pkg::COUNT_FULL)
                begin
                    sum_at[pos] += v;
                    isum_at[pos] += longint'(v) / 65536;
                    cnt_at[pos]++;
                end
                pos++;
                if (pos > longest)
                    longest = pos;
            end
            else
                idx_dropped = 1'b1;
            if (wr_pos < elm_pkg::MAX_LEN)
            begin
                cat_at[wr_pos] = v;
                wr_pos++;
            end
            else
                cat_dropped = 1'b1;
        end
        if (mt || eol || eos)
            pos = 0;
        if (!eos)
            return;

        if (!m_enable)
            kind = elm_pkg::KIND_APPEND;
        else if (m_mode == elm_pkg::MODE_HIGHEST)
            kind = elm_pkg::KIND_HIGHEST;
        else if (m_mode == elm_pkg::MODE_AVERAGE)
            kind = elm_pkg::KIND_AVERAGE;
        else
            kind = elm_pkg::KIND_APPEND;
        cap_i = m_cap;
        if (kind != elm_pkg::KIND_APPEND)
        begin
            len = longest;
            ovf = idx_dropped;
        end
        else if (cap_i >= 0)
        begin
            len = (cap_i > elm_pkg::MAX_LEN) ? elm_pkg::MAX_LEN : cap_i;
            ovf = cat_dropped && cap_i > elm_pkg::MAX_LEN;
        end
        else
        begin
            len = wr_pos;
            ovf = cat_dropped;
        end

        m.overflow = ovf;
        if (len == 0)
        begin
            m.value = '0;
            m.is_last = 1'b1;
            m.empty_result = 1'b1;
            merged_q = {merged_q, m};
        end
        for (int i = 0; i < len; i++)
        begin
            r = 0;
            case (kind)
                elm_pkg::KIND_HIGHEST:
                    if (cnt_at[i] != 0)
                        r = peak_at[i];
                elm_pkg::KIND_AVERAGE:
                    if (cnt_at[i] != 0)
                        r = m_int_avg ? (isum_at[i] / cnt_at[i]) <<< 16
                                      : rounded_mean(sum_at[i], cnt_at[i]);
                default:
                    if (i < wr_pos)
                        r = cat_at[i];
            endcase
            m.value = r[31:0];
            m.is_last = (i + 1 == len);
            m.empty_result = 1'b0;
            merged_q = {merged_q, m};
        end
        clear_set_state();
    endtask

    task automatic send_item(input logic signed [31:0] v, input logic eol,
                             input logic mt, input logic eos);
        int g;
        g = src_gaps ? pick_gap() : 0;
        if (g > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_if.valid         <= 1'b1;
        in_if.element_value <= v;
        in_if.end_of_list   <= eol;
        in_if.empty_marker  <= mt;
        in_if.end_of_set    <= eos;
        do
            @(posedge clk);
        while (!in_if.ready);
        fold_item(v, eol, mt, eos);
        items_sent++;
    endtask

    // One list of random elements; when it closes the set the final
    // end_of_list mark is left random since end_of_set ends the list anyway.
    task automatic send_list(input int len, input bit closes_set);
        logic eol;
        for (int k = 0; k < len; k++)
        begin
            if (k == len - 1)
                eol = closes_set ? 1'($urandom_range(0, 1)) : 1'b1;
            else
                eol = ($urandom_range(0, 30) == 0);
            send_item(rand_value(), eol, 1'b0, closes_set && k == len - 1);
        end
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (merged_q.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    // Writes all four registers back to back; caller makes sure the block is idle.
    task automatic configure(input logic en, input logic [2:0] mode,
                             input logic signed [7:0] cap, input logic iavg);
        logic [elm_pkg::CFG_IDX_W-1:0]  idx  [4];
        logic [elm_pkg::CFG_DATA_W-1:0] vals [4];
        idx[0] = elm_pkg::CFG_MERGE_ENABLE;
        idx[1] = elm_pkg::CFG_MERGE_MODE;
        idx[2] = elm_pkg::CFG_SIZE_CAP;
        idx[3] = elm_pkg::CFG_INTEGER_AVERAGE;
        vals[0] = elm_pkg::CFG_DATA_W'(en);
        vals[1] = elm_pkg::CFG_DATA_W'(mode);
        vals[2] = cap;
        vals[3] = elm_pkg::CFG_DATA_W'(iavg);
        for (int k = 0; k < 4; k++)
        begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx[k];
            cfg_if.data  <= vals[k];
            do
                @(posedge clk);
            while (!cfg_if.ready);
        end
        cfg_if.valid <= 1'b0;
        m_enable  = en;
        m_mode    = mode;
        m_cap     = cap;
        m_int_avg = iavg;
    endtask

    task automatic report_error(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        $display("ERROR t=%0t result %0d %s: want %h got %h",
                 $time, results_seen, what, want, got);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (merged_q.size() == 0)
                report_error("unexpected transfer", '0, out_if.result_value);
            else
            begin
                head_r = merged_q.pop_front();
                if (out_if.result_value !== head_r.value)
                    report_error("result_value", head_r.value, out_if.result_value);
                if (out_if.is_last !== head_r.is_last)
                    report_error("is_last", 32'(head_r.is_last), 32'(out_if.is_last));
                if (out_if.empty_result !== head_r.empty_result)
                    report_error("empty_result", 32'(head_r.empty_result),
                                 32'(out_if.empty_result));
                if (out_if.overflow !== head_r.overflow)
                    report_error("overflow", 32'(head_r.overflow), 32'(out_if.overflow));
            end
            results_seen++;
        end
    end

    // Result receiver: random stalls, plus one long hold on request.
    initial
    begin : result_sink
        int gap_left;
        int held;
        gap_left = 0;
        out_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_cycles > 0)
            begin
                held = sink_hold_cycles;
                sink_hold_cycles = 0;
                out_if.ready <= 1'b0;
                repeat (held - 1) @(posedge clk);
            end
            else if (gap_left > 0)
            begin
                out_if.ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                out_if.ready <= 1'b1;
                if (sink_gaps && $urandom_range(0, 3) == 0)
                    gap_left = pick_gap();
            end
        end
    end

    // Reset defaults: uncapped append.
    task automatic test_default_append();
        send_item(32'sh0007_8000, 1'b0, 1'b0, 1'b0);
        send_item(-32'sh0003_0000, 1'b1, 1'b0, 1'b0);
        send_item(Q_MAX, 1'b1, 1'b1, 1'b0);
        send_item(Q_MAX, 1'b0, 1'b0, 1'b1);
    endtask

    task automatic test_highest();
        wait_idle();
        configure(1'b1, elm_pkg::MODE_HIGHEST, -8'sd1, 1'b0);
        send_item(Q_MIN, 1'b0, 1'b0, 1'b0);
        send_item(Q_ONE, 1'b0, 1'b0, 1'b0);
        send_item(32'sh0000_0005, 1'b1, 1'b0, 1'b0);
        send_item(Q_MAX, 1'b0, 1'b0, 1'b0);
        send_item(-32'sh0002_0000, 1'b0, 1'b0, 1'b0);
        send_item(Q_MIN, 1'b0, 1'b1, 1'b0);       // empty marker cuts the list short
        send_item(Q_MIN, 1'b0, 1'b0, 1'b1);
    endtask

    task automatic test_average();
        wait_idle();
        configure(1'b1, elm_pkg::MODE_AVERAGE, -8'sd1, 1'b0);
        send_item(32'sh0000_0001, 1'b0, 1'b0, 1'b0);
        send_item(-32'sh0000_0001, 1'b0, 1'b0, 1'b0);
        send_item(32'sh0001_8000, 1'b1, 1'b0, 1'b0);
        send_item(32'sh0000_0002, 1'b0, 1'b0, 1'b0);
        send_item(-32'sh0000_0002, 1'b0, 1'b0, 1'b0);
        send_item(Q_MAX, 1'b1, 1'b0, 1'b1);
        wait_idle();
        configure(1'b1, elm_pkg::MODE_AVERAGE, -8'sd1, 1'b1);
        send_item(32'shFFFE_8000, 1'b0, 1'b0, 1'b0);
        send_item(32'sh0002_8000, 1'b1, 1'b0, 1'b0);
        send_item(Q_ONE, 1'b0, 1'b0, 1'b0);
        send_item(Q_MIN, 1'b1, 1'b0, 1'b0);
        send_item(-32'sh0003_4000, 1'b0, 1'b0, 1'b1);
    endtask

    task automatic test_append_variants();
        wait_idle();
        configure(1'b0, elm_pkg::MODE_HIGHEST, 8'sd3, 1'b0);  // merging off: mode ignored
        send_list(2, 1'b0);
        send_list(2, 1'b1);
        wait_idle();
        configure(1'b1, MODE_ALT2, 8'sd5, 1'b0);
        send_list(2, 1'b1);
        wait_idle();
        configure(1'b1, MODE_ALT3, -8'sd1, 1'b0);
        send_list(1, 1'b0);
        send_list(1, 1'b1);
        wait_idle();
        configure(1'b1, elm_pkg::MODE_APPEND, 8'sd0, 1'b1);
        send_list(1, 1'b1);
    endtask

    task automatic test_empty_sets();
        wait_idle();
        configure(1'b1, elm_pkg::MODE_HIGHEST, -8'sd1, 1'b0);
        send_item(Q_MAX, 1'b0, 1'b1, 1'b1);
        wait_idle();
        configure(1'b1, elm_pkg::MODE_AVERAGE, -8'sd1, 1'b1);
        send_item(Q_MIN, 1'b1, 1'b1, 1'b1);
        wait_idle();
        configure(1'b1, elm_pkg::MODE_APPEND, -8'sd1, 1'b0);
        send_item(Q_ONE, 1'b1, 1'b1, 1'b0);
        send_item(Q_ONE, 1'b0, 1'b1, 1'b1);
    endtask

    // 33 lists reach index 0; the count saturates at 31 so the last two
    // land only in the maximum.
    task automatic test_count_saturation();
        logic [2:0] modes [2];
        modes[0] = elm_pkg::MODE_AVERAGE;
        modes[1] = elm_pkg::MODE_HIGHEST;
        for (int m = 0; m < 2; m++)
        begin
            wait_idle();
            configure(1'b1, modes[m], -8'sd1, 1'b0);
            for (int i = 0; i < elm_pkg::COUNT_FULL + 2; i++)
                send_item((i < elm_pkg::COUNT_FULL) ? i * Q_ONE : Q_MAX, 1'b1, 1'b0,
                          i == elm_pkg::COUNT_FULL + 1);
        end
    endtask

    // One list past the store depth, then a capped concatenation past it
    // with the cap above the depth.
    task automatic test_long_lists();
        wait_idle();
        configure(1'b1, elm_pkg::MODE_HIGHEST, -8'sd1, 1'b0);
        send_list(elm_pkg::MAX_LEN + 1, 1'b1);
        wait_idle();
        configure(1'b1, elm_pkg::MODE_APPEND, 8'sd100, 1'b0);
        send_list(30, 1'b0);
        send_list(30, 1'b0);
        send_list(elm_pkg::MAX_LEN + 1 - 60, 1'b1);
    endtask

    // Receiver holds off while several sets are offered, so the input stalls.
    task automatic test_backpressure();
        wait_idle();
        configure(1'b1, elm_pkg::MODE_HIGHEST, -8'sd1, 1'b0);
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
        sink_hold_cycles = HOLD_CYCLES;
        repeat (3)
        begin
            send_list(4, 1'b0);
            send_list(3, 1'b1);
        end
        wait_idle();
        src_gaps = 1'b1;
        sink_gaps = 1'b1;
    endtask

    task automatic test_random();
        int          first;
        int          n_lists;
        int          len;
        int          r;
        bit          last;
        logic [2:0]  mode;
        logic signed [7:0] cap;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                wait_idle();
                r = $urandom_range(0, 9);
                mode = (r == 0) ? elm_pkg::MODE_APPEND : (r == 1) ? MODE_ALT2 :
                       (r == 2) ? MODE_ALT3 : (r < 6) ? elm_pkg::MODE_HIGHEST
                                                      : elm_pkg::MODE_AVERAGE;
                r = $urandom_range(0, 9);
                cap = (r < 5) ? -8'sd1 : (r == 5) ? 8'sd0 : (r == 6) ? 8'sd64 :
                      8'($urandom_range(1, 12));
                configure($urandom_range(0, 4) != 0, mode, cap, 1'($urandom_range(0, 1)));
            end
            src_gaps = ($urandom_range(0, 3) != 0);
            sink_gaps = ($urandom_range(0, 3) != 0);
            n_lists = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14)
                                                   : $urandom_range(1, 5);
            for (int li = 0; li < n_lists; li++)
            begin
                last = (li == n_lists - 1);
                r = $urandom_range(0, 99);
                if (r < 8)
                    send_item(rand_value(), 1'($urandom_range(0, 1)), 1'b1, last);
                else if (r < 15)
                begin
                    // list broken off by an empty marker
                    repeat ($urandom_range(1, 4))
                        send_item(rand_value(), 1'b0, 1'b0, 1'b0);
                    send_item(rand_value(), 1'($urandom_range(0, 1)), 1'b1, last);
                end
                else
                begin
                    len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 24)
                                                       : $urandom_range(1, 6);
                    send_list(len, last);
                end
            end
        end
        src_gaps = 1'b1;
        sink_gaps = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.element_value = '0;
        in_if.end_of_list = 1'b0;
        in_if.empty_marker = 1'b0;
        in_if.end_of_set = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = elm_pkg::CFG_MERGE_ENABLE;
        cfg_if.data = '0;
        m_enable = 1'b0;
        m_mode = elm_pkg::MODE_APPEND;
        m_cap = -8'sd1;
        m_int_avg = 1'b0;
        for (int i = 0; i < elm_pkg::MAX_LEN; i++)
        begin
            peak_at[i] = '0;
            sum_at[i] = 0;
            isum_at[i] = 0;
            cat_at[i] = '0;
        end
        clear_set_state();
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        src_gaps = 1'b1;
        sink_gaps = 1'b1;
        sink_hold_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_append();
        test_highest();
        test_average();
        test_append_variants();
        test_empty_sets();
        test_count_saturation();
        test_long_lists();
        test_backpressure();
        test_random();

        wait_idle();
        repeat (END_SETTLE) @(posedge clk);
        if (mismatches == 0 && merged_q.size() == 0)
            $display("elementwise_list_merger: match");
        else
            $display("elementwise_list_merger: mismatch");
        $finish;
    end

endmodule
